@@ src/sscv_pkg.sv @@
// Shared types and constants of the stereo SAD cost volume core.
package sscv_pkg;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 11;
   localparam int DISP_W     = 6;
   localparam int COST_W     = 8;
   localparam int ROW_W      = 11;
   localparam int ROW_LIMIT  = 2048;
   localparam int CALC_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_DISP      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RADIUS = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] left_pixel;
      logic [PIX_W-1:0] right_pixel;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] center_column;
      logic [COORD_W-1:0] center_row;
      logic [DISP_W-1:0]  disparity;
      logic [COST_W-1:0]  match_cost;
      logic               last_of_pixel;
   } rsp_type;

   typedef struct packed {
      logic stream;
      logic accum;
      logic clear;
      logic divide;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_STREAM = 6'b000100,
      ST_WAIT   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_OUTPUT = 6'b100000
   } state_type;

endpackage

@@ src/sscv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sscv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sscv_cell.sv @@
// One disparity cell: right pixel delay tap, SAD accumulator, serial divider, result shift.
module sscv_cell #(
   parameter int SUM_W  = 16,
   parameter int AREA_W = 8
) (
   input  logic                       clock,
   input  sscv_pkg::cell_ctl_type     ctl,
   input  logic [AREA_W-1:0]          area,
   input  logic [sscv_pkg::PIX_W-1:0] left_pixel,
   input  logic [sscv_pkg::PIX_W-1:0] right_in,
   output logic [sscv_pkg::PIX_W-1:0] right_out,
   input  logic [SUM_W-1:0]           acc_next,
   output logic [SUM_W-1:0]           acc_out
);
   import sscv_pkg::*;

   logic [PIX_W-1:0]  rpix_ff, rpix_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [AREA_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0]  diff;
   logic [AREA_W:0]   trial;
   logic              ge;
   logic [AREA_W:0]   rem_step;

   always_comb begin
      diff     = (left_pixel > right_in) ? left_pixel - right_in : right_in - left_pixel;
      trial    = {rem_ff, acc_ff[SUM_W-1]};
      ge       = trial >= {1'b0, area};
      rem_step = ge ? trial - {1'b0, area} : trial;

      rpix_in = ctl.stream ? right_in : rpix_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (ctl.shift) begin
         acc_in = acc_next;
      end else if (ctl.divide) begin
         // restoring division, quotient bits shift in at the bottom
         acc_in = {acc_ff[SUM_W-2:0], ge};
         rem_in = rem_step[AREA_W-1:0];
      end else if (ctl.accum) begin
         acc_in = (ctl.clear ? '0 : acc_ff) + SUM_W'(diff);
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rpix_ff <= rpix_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
   end

   assign right_out = rpix_ff;
   assign acc_out   = acc_ff;

endmodule

@@ src/stereo_sad_cost_volume_core.sv @@
// Top level of the stereo SAD cost volume core: line stores, sequencer and cell chain.
//
// Usage: left/right pixel pairs enter in raster order on req_* (valid/ready);
// costs leave on rsp_*, one per transfer, disparity 0 first, last_of_pixel on
// the final disparity of a pixel. Sizes are written on csr_* while idle.
// A pixel that completes no interior window is only written to the line
// stores. A pixel that completes one is written too, then its window is
// streamed through the line store read port, 2r+1 rows of 2r+nd columns (one
// column per cycle, all disparity cells in parallel); a wait state covers the
// read latency, the cells divide serially over SUM_W (16 by default) quotient
// bits, then the nd costs shift out, one per cycle unless the receiver stalls.
// After reset the line stores are cleared, one entry a cycle, while
// req_ready stays low; configuration writes are taken throughout.
// Registers return to 640 x 480, 20 disparities, radius 5.
// The result sits in an output register: while the receiver stalls, the
// shift-out of costs pauses; once the last cost is in that register the next
// pixel may already be taken.
module stereo_sad_cost_volume_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_RADIUS = 7,
   parameter int MAX_DISP   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sscv_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sscv_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [sscv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sscv_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import sscv_pkg::*;

   localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
   localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int SLOT_W    = $clog2(RING_ROWS);
   localparam int SUM_W     = $clog2(RING_ROWS * RING_ROWS * 255 + 1);
   localparam int AREA_W    = $clog2(RING_ROWS * RING_ROWS + 1);
   localparam int ND_W      = $clog2(MAX_DISP + 1);
   localparam int D_W       = $clog2(MAX_DISP);
   localparam int K_W       = $clog2(2 * MAX_RADIUS + MAX_DISP + 1);
   localparam int DC_W      = $clog2(SUM_W + 1);

   // configuration
   logic [11:0] width_ff, height_ff;
   logic [6:0]  ndisp_ff;
   logic [2:0]  radius_ff;

   // control
   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [SLOT_W-1:0]  j_ff, j_in;
   logic signed [CALC_W-1:0] c_ff, c_in;
   logic [SLOT_W-1:0]  yslot_ff, yslot_in;
   logic               p_stream_ff, p_stream_in;
   logic               p_accum_ff, p_accum_in;
   logic               p_clear_ff, p_clear_in;
   logic               p_neg_ff, p_neg_in;
   logic [DC_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [D_W-1:0]     dcount_ff, dcount_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-pixel latched values
   logic [ND_W-1:0]    nd_lat_ff, nd_lat_in;
   logic [SLOT_W-1:0]  r2_lat_ff, r2_lat_in;
   logic [K_W-1:0]     klast_ff, klast_in;
   logic [K_W-1:0]     kacc_ff, kacc_in;
   logic signed [CALC_W-1:0] cstart_ff, cstart_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // effective sizes and window check
   logic [CALC_W-1:0] w_eff, h_eff, nd_eff, r_sat, r_eff, r2;
   logic [CALC_W-1:0] col_x, row_x, slot_x, cxw, cyw;
   logic              emit, accept, out_load, col_last, row_last;

   logic [ADDR_W-1:0] wr_addr, rd_addr, ram_waddr;
   logic              ram_we;
   logic [PIX_W-1:0]  left_wdata, right_wdata, left_rd, right_rd;

   cell_ctl_type      cell_ctl;
   logic [PIX_W-1:0]  rpix_chain [MAX_DISP+1];
   logic [SUM_W-1:0]  acc_chain [MAX_DISP+1];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      w_eff = CALC_W'(width_ff);
      if (w_eff == '0) w_eff = CALC_W'(1);
      if (w_eff > CALC_W'(MAX_WIDTH)) w_eff = CALC_W'(MAX_WIDTH);
      h_eff = CALC_W'(height_ff);
      if (h_eff == '0) h_eff = CALC_W'(1);
      if (h_eff > CALC_W'(ROW_LIMIT)) h_eff = CALC_W'(ROW_LIMIT);
      nd_eff = CALC_W'(ndisp_ff);
      if (nd_eff > CALC_W'(MAX_DISP)) nd_eff = CALC_W'(MAX_DISP);
      r_sat = CALC_W'(radius_ff);
      if (r_sat > CALC_W'(MAX_RADIUS)) r_sat = CALC_W'(MAX_RADIUS);
      r_eff = r_sat;
      if (nd_eff != '0 && r_sat > nd_eff - 1'b1) r_eff = nd_eff - 1'b1;
      r2 = r_eff << 1;

      col_x  = CALC_W'(col_ff);
      row_x  = CALC_W'(row_ff);
      slot_x = CALC_W'(slot_ff);
      cxw    = col_x - r_eff;
      cyw    = row_x - r_eff;
      emit   = (nd_eff != '0) && (col_x >= r_eff) && (row_x >= r_eff)
               && (col_x < w_eff) && (row_x < h_eff)
               && (cxw >= nd_eff) && (cxw + nd_eff < w_eff)
               && (cyw >= nd_eff) && (cyw + nd_eff < h_eff);
      col_last = (col_x + 1'b1 >= w_eff);
      row_last = (row_x + 1'b1 >= h_eff);
   end

   assign wr_addr = ADDR_W'(slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_ff);
   assign rd_addr = ADDR_W'(yslot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_ff[COL_W-1:0]);

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      slot_in     = slot_ff;
      clr_addr_in = clr_addr_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      c_in        = c_ff;
      yslot_in    = yslot_ff;
      p_stream_in = 1'b0;
      p_accum_in  = 1'b0;
      p_clear_in  = 1'b0;
      p_neg_in    = 1'b0;
      div_cnt_in  = div_cnt_ff;
      dcount_in   = dcount_ff;
      nd_lat_in   = nd_lat_ff;
      r2_lat_in   = r2_lat_ff;
      klast_in    = klast_ff;
      kacc_in     = kacc_ff;
      cstart_in   = cstart_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      area_in     = area_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (col_last) begin
                  col_in = '0;
                  if (row_last) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = row_ff + 1'b1;
                     slot_in = (slot_ff == SLOT_W'(RING_ROWS - 1)) ? '0 : slot_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (emit) begin
                  nd_lat_in = ND_W'(nd_eff);
                  r2_lat_in = SLOT_W'(r2);
                  klast_in  = K_W'(r2 + nd_eff - 1'b1);
                  kacc_in   = K_W'(nd_eff - 1'b1);
                  cstart_in = $signed(col_x - r2 - nd_eff + 1'b1);
                  c_in      = $signed(col_x - r2 - nd_eff + 1'b1);
                  cx_in     = COORD_W'(cxw);
                  cy_in     = COORD_W'(cyw);
                  area_in   = AREA_W'((r2 + 1'b1) * (r2 + 1'b1));
                  yslot_in  = (slot_x >= r2) ? SLOT_W'(slot_x - r2)
                                             : SLOT_W'(slot_x + CALC_W'(RING_ROWS) - r2);
                  k_in      = '0;
                  j_in      = '0;
                  state_in  = ST_STREAM;
               end
            end
         end
         ST_STREAM: begin
            p_stream_in = 1'b1;
            p_accum_in  = (k_ff >= kacc_ff);
            p_clear_in  = (j_ff == '0) && (k_ff == kacc_ff);
            p_neg_in    = c_ff[CALC_W-1];
            if (k_ff == klast_ff) begin
               k_in     = '0;
               c_in     = cstart_ff;
               j_in     = j_ff + 1'b1;
               yslot_in = (yslot_ff == SLOT_W'(RING_ROWS - 1)) ? '0 : yslot_ff + 1'b1;
               if (j_ff == r2_lat_ff) begin
                  state_in = ST_WAIT;
               end
            end else begin
               k_in = k_ff + 1'b1;
               c_in = c_ff + CALC_W'(1);
            end
         end
         ST_WAIT: begin
            div_cnt_in = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DC_W'(SUM_W - 1)) begin
               dcount_in = '0;
               state_in  = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.center_column = cx_ff;
               rsp_data_in.center_row    = cy_ff;
               rsp_data_in.disparity     = DISP_W'(dcount_ff);
               rsp_data_in.match_cost    = acc_chain[0][COST_W-1:0];
               rsp_data_in.last_of_pixel = (dcount_ff == D_W'(nd_lat_ff - 1'b1));
               dcount_in = dcount_ff + 1'b1;
               if (dcount_ff == D_W'(nd_lat_ff - 1'b1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         clr_addr_ff  <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         p_stream_ff  <= 1'b0;
         p_accum_ff   <= 1'b0;
         p_clear_ff   <= 1'b0;
         p_neg_ff     <= 1'b0;
         div_cnt_ff   <= '0;
         dcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         nd_lat_ff    <= '0;
         width_ff     <= 12'd640;
         height_ff    <= 12'd480;
         ndisp_ff     <= 7'd20;
         radius_ff    <= 3'd5;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         clr_addr_ff  <= clr_addr_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         p_stream_ff  <= p_stream_in;
         p_accum_ff   <= p_accum_in;
         p_clear_ff   <= p_clear_in;
         p_neg_ff     <= p_neg_in;
         div_cnt_ff   <= div_cnt_in;
         dcount_ff    <= dcount_in;
         rsp_valid_ff <= rsp_valid_in;
         nd_lat_ff    <= nd_lat_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data;
               CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data;
               CSR_NUM_DISP:      ndisp_ff  <= csr_write_data[6:0];
               CSR_WINDOW_RADIUS: radius_ff <= csr_write_data[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff        <= c_in;
      yslot_ff    <= yslot_in;
      r2_lat_ff   <= r2_lat_in;
      klast_ff    <= klast_in;
      kacc_ff     <= kacc_in;
      cstart_ff   <= cstart_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      area_ff     <= area_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // line stores: clearing pass shares the write port with incoming pixels
   assign ram_we      = (state_ff == ST_CLEAR) || accept;
   assign ram_waddr   = (state_ff == ST_CLEAR) ? clr_addr_ff : wr_addr;
   assign left_wdata  = (state_ff == ST_CLEAR) ? '0 : req_data.left_pixel;
   assign right_wdata = (state_ff == ST_CLEAR) ? '0 : req_data.right_pixel;

   sscv_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (left_wdata),
      .rd_addr (rd_addr),
      .rd_data (left_rd)
   );

   sscv_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (right_wdata),
      .rd_addr (rd_addr),
      .rd_data (right_rd)
   );

   // cell d sees the right pixel d columns back; columns left of 0 read as zero
   always_comb begin
      cell_ctl.stream = p_stream_ff;
      cell_ctl.accum  = p_accum_ff;
      cell_ctl.clear  = p_clear_ff;
      cell_ctl.divide = (state_ff == ST_DIVIDE);
      cell_ctl.shift  = out_load;
   end

   assign rpix_chain[0]        = p_neg_ff ? '0 : right_rd;
   assign acc_chain[MAX_DISP]  = '0;

   for (genvar d = 0; d < MAX_DISP; d++) begin : g_cell
      sscv_cell #(.SUM_W(SUM_W), .AREA_W(AREA_W)) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .area       (area_ff),
         .left_pixel (left_rd),
         .right_in   (rpix_chain[d]),
         .right_out  (rpix_chain[d+1]),
         .acc_next   (acc_chain[d+1]),
         .acc_out    (acc_chain[d])
      );
   end

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !p_stream_ff)
      else $error("window stream still in flight while idle");

   a_stream_has_disp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (nd_lat_ff != '0))
      else $error("streaming a pixel with no disparities");

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUTPUT) |-> (ND_W'(dcount_ff) < nd_lat_ff))
      else $error("cost index past disparity count");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (out_load && (dcount_ff == D_W'(nd_lat_ff - 1'b1)))
      |=> (rsp_valid_ff && rsp_data_ff.last_of_pixel && (state_ff == ST_IDLE)))
      else $error("final cost of pixel not flagged");

endmodule

@@ tb/sscv_checker.sv @@
// Cost volume checker: watches the channels, predicts the costs and compares them.
`timescale 1ns / 1ps
module sscv_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  sscv_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  sscv_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_enable,
   input  logic [sscv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sscv_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               fail_count,
   output int                               pending_costs
);
   import sscv_pkg::*;

   localparam int LINE_LEN  = 2048;
   localparam int RADIUS_MX = 7;
   localparam int DISP_MX   = 64;
   localparam int RING      = 2 * RADIUS_MX + 1;

   logic [PIX_W-1:0] left_rows  [RING*LINE_LEN];
   logic [PIX_W-1:0] right_rows [RING*LINE_LEN];
   int unsigned      col_pos, row_pos;
   logic [11:0]      cfg_width, cfg_height;
   logic [6:0]       cfg_ndisp;
   logic [2:0]       cfg_radius;
   rsp_type          cost_queue[$];

   initial begin
      fail_count = 0;
      foreach (left_rows[i]) begin
         left_rows[i]  = '0;
         right_rows[i] = '0;
      end
   end

   assign pending_costs = cost_queue.size();

   function automatic int unsigned slot(int unsigned row, int unsigned col);
      return (row % RING) * LINE_LEN + (col % LINE_LEN);
   endfunction

   task automatic predict_costs(req_type px);
      int unsigned w, h, nd, r, cx, cy, area, sum, lv, rv;
      rsp_type     cost;
      w  = cfg_width;
      h  = cfg_height;
      nd = cfg_ndisp;
      r  = cfg_radius;
      if (w < 1) w = 1;
      if (w > LINE_LEN) w = LINE_LEN;
      if (h < 1) h = 1;
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      if (nd > DISP_MX) nd = DISP_MX;
      if (r > RADIUS_MX) r = RADIUS_MX;
      if (nd >= 1 && r > nd - 1) r = nd - 1;
      left_rows[slot(row_pos, col_pos)]  = px.left_pixel;
      right_rows[slot(row_pos, col_pos)] = px.right_pixel;
      if (nd > 0 && col_pos >= r && row_pos >= r && col_pos < w && row_pos < h) begin
         cx = col_pos - r;
         cy = row_pos - r;
         if (cx >= nd && cx + nd < w && cy >= nd && cy + nd < h) begin
            area = (2 * r + 1) * (2 * r + 1);
            for (int unsigned d = 0; d < nd; d++) begin
               sum = 0;
               for (int unsigned y = cy - r; y <= cy + r; y++)
                  for (int unsigned x = cx - r; x <= cx + r; x++) begin
                     lv = left_rows[slot(y, x)];
                     // right pixels left of column 0 read as zero
                     rv = (x >= d) ? right_rows[slot(y, x - d)] : 0;
                     sum += (lv > rv) ? lv - rv : rv - lv;
                  end
               cost.center_column = cx[COORD_W-1:0];
               cost.center_row    = cy[COORD_W-1:0];
               cost.disparity     = d[DISP_W-1:0];
               cost.match_cost    = 8'((sum / area) & 32'hFF);
               cost.last_of_pixel = (d + 1 == nd);
               cost_queue.push_back(cost);
            end
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         col_pos    = 0;
         row_pos    = 0;
         cfg_width  = 12'd640;
         cfg_height = 12'd480;
         cfg_ndisp  = 7'd20;
         cfg_radius = 3'd5;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   cfg_width  = csr_write_data;
               CSR_IMAGE_HEIGHT:  cfg_height = csr_write_data;
               CSR_NUM_DISP:      cfg_ndisp  = csr_write_data[6:0];
               CSR_WINDOW_RADIUS: cfg_radius = csr_write_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_costs(req_data);
         if (rsp_valid && rsp_ready) begin
            if (cost_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected cost transfer: %p", rsp_data);
            end else begin
               want = cost_queue.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("cost mismatch: col %0d/%0d row %0d/%0d disp %0d/%0d cost %0d/%0d last %0b/%0b (exp/act)",
                              want.center_column, rsp_data.center_column,
                              want.center_row, rsp_data.center_row,
                              want.disparity, rsp_data.disparity,
                              want.match_cost, rsp_data.match_cost,
                              want.last_of_pixel, rsp_data.last_of_pixel);
               end
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, pixel stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb;
   import sscv_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   int                     fail_count, pending_costs;
   bit                     no_idle = 1'b0;
   int                     quiet_cycles = 0;
   int                     pixels_sent = 0;

   stereo_sad_cost_volume_core u_top (.*);

   sscv_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index        = idx;
      csr_write_data   = val;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_geometry(int w, int h, int nd, int r);
      csr_write(CSR_IMAGE_WIDTH, w[11:0]);
      csr_write(CSR_IMAGE_HEIGHT, h[11:0]);
      csr_write(CSR_NUM_DISP, nd[11:0]);
      csr_write(CSR_WINDOW_RADIUS, r[11:0]);
   endtask

   // entered and left at a falling edge; valid stays up when there is no gap
   task automatic send_pixel(logic [7:0] lp, logic [7:0] rp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.left_pixel  = lp;
      req_data.right_pixel = rp;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   // drain, then allow for a pixel that is still being worked on
   task automatic settle();
      req_valid = 1'b0;
      wait (pending_costs == 0);
      repeat (60) @(negedge clock);
   endtask

   task automatic random_frame(int nd);
      int w, h, r;
      w = 2 * nd + 1 + $urandom_range(0, 4);
      h = 2 * nd + 1 + $urandom_range(0, 3);
      r = $urandom_range(0, 7);
      settle();
      set_geometry(w, h, nd, r);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00);
         else
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      no_idle = 1'b0;
   endtask

   // receiver: random stall per cost, sometimes none at all
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         rsp_ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // smallest frame with one interior pixel, extreme pixel values
      set_geometry(5, 5, 2, 1);
      for (int i = 0; i < 25; i++)
         send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF);
      // radius zero: single pixel window
      settle();
      set_geometry(5, 5, 2, 0);
      for (int i = 0; i < 25; i++)
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      // out-of-range registers: saturated sizes, no interior reached
      settle();
      set_geometry(4095, 4095, 127, 7);
      for (int i = 0; i < 8; i++) send_pixel(8'hFF, 8'h00);
      settle();
      set_geometry(0, 0, 0, 0);
      for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'hFF);
      settle();
      set_geometry(2048, 2048, 64, 7);
      for (int i = 0; i < 4; i++) send_pixel(8'h55, 8'hAA);

      while (pixels_sent < 410)
         random_frame($urandom_range(2, 4));

      req_valid = 1'b0;
      wait (pending_costs == 0);
      repeat (2000) @(negedge clock);
      if (fail_count == 0 && pending_costs == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ stereo_sad_cost_volume_core.f @@
src/sscv_pkg.sv
src/sscv_ram.sv
src/sscv_cell.sv
src/stereo_sad_cost_volume_core.sv
tb/sscv_checker.sv
tb/tb.sv
